// ----- rtl/core/mtp_pkg.sv -----
// ----------------------------------------------------------------------------
// mtp_pkg
// Shared types and codes for the MIDI track event parser.
// ----------------------------------------------------------------------------
package mtp_pkg;

  // Result kinds
  localparam logic [1:0] KIND_CHAN     = 2'd0;
  localparam logic [1:0] KIND_TEMPO    = 2'd1;
  localparam logic [1:0] KIND_TSIG     = 2'd2;
  localparam logic [1:0] KIND_BAD_META = 2'd3;

  // Status and meta codes
  localparam logic [7:0] STATUS_META  = 8'hff;
  localparam logic [7:0] STATUS_SYSEX = 8'hf0;
  localparam logic [7:0] STATUS_ESC   = 8'hf7;
  localparam logic [7:0] META_TEMPO   = 8'h51;
  localparam logic [7:0] META_TSIG    = 8'h58;

  // Channel message classes (upper nibble of status)
  localparam logic [3:0] HI_AFTERTOUCH = 4'ha;
  localparam logic [3:0] HI_PROGRAM    = 4'hc;
  localparam logic [3:0] HI_PRESSURE   = 4'hd;

  // Expected meta body lengths
  localparam logic [27:0] LEN_TEMPO = 28'd3;
  localparam logic [27:0] LEN_TSIG  = 28'd4;

  // Registered input item
  typedef struct packed {
    logic       valid;
    logic [7:0] track_byte;
    logic       track_start;
  } stage_t;

  // One result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] tick;
    logic [7:0]  status;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [1:0]  data_count;
    logic [23:0] tempo_value;
    logic [7:0]  numerator;
    logic [7:0]  denominator_power;
    logic [7:0]  clocks_per_click;
    logic [7:0]  thirty_seconds_per_quarter;
  } res_t;

  // Result handed from the parser to the output register
  typedef struct packed {
    logic valid;
    res_t res;
  } res_load_t;

endpackage

// ----- rtl/core/mtp_in_if.sv -----
// ----------------------------------------------------------------------------
// mtp_in_if
// Input channel: one track byte per item with a track start flag.
// ----------------------------------------------------------------------------
interface mtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] track_byte;
  logic       track_start;

  modport source (output valid, output track_byte, output track_start, input ready);
  modport sink   (input valid, input track_byte, input track_start, output ready);
endinterface

// ----- rtl/core/mtp_out_if.sv -----
// ----------------------------------------------------------------------------
// mtp_out_if
// Result channel: one parsed event per item.
// ----------------------------------------------------------------------------
interface mtp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] tick;
  logic [7:0]  status;
  logic [6:0]  first_data;
  logic [6:0]  second_data;
  logic [1:0]  data_count;
  logic [23:0] tempo_value;
  logic [7:0]  numerator;
  logic [7:0]  denominator_power;
  logic [7:0]  clocks_per_click;
  logic [7:0]  thirty_seconds_per_quarter;

  modport source (
    output valid, output kind, output tick, output status, output first_data,
    output second_data, output data_count, output tempo_value, output numerator,
    output denominator_power, output clocks_per_click,
    output thirty_seconds_per_quarter, input ready
  );
  modport sink (
    input valid, input kind, input tick, input status, input first_data,
    input second_data, input data_count, input tempo_value, input numerator,
    input denominator_power, input clocks_per_click,
    input thirty_seconds_per_quarter, output ready
  );
endinterface

// ----- rtl/core/mtp_in_stage.sv -----
// ----------------------------------------------------------------------------
// mtp_in_stage
// Input register: captures one byte item and holds it until the parser
// consumes it.
// ----------------------------------------------------------------------------
module mtp_in_stage
  import mtp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_track_byte,
  input  logic       in_track_start,
  input  logic       adv,
  output stage_t     stage
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       start_r;

  // Accept when empty or when the held item moves on this cycle
  assign in_ready  = !valid_r || adv;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r  <= in_track_byte;
      start_r <= in_track_start;
    end
  end

  assign stage.valid       = valid_r;
  assign stage.track_byte  = byte_r;
  assign stage.track_start = start_r;

endmodule

// ----- rtl/core/mtp_parse_core.sv -----
// ----------------------------------------------------------------------------
// mtp_parse_core
// Track parser state: delta time accumulation, running status, meta and
// sysex length handling. Updates once per consumed byte.
// ----------------------------------------------------------------------------
module mtp_parse_core
  import mtp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  stage_t    stage,
  input  logic      out_free,
  output logic      adv,
  output res_load_t load
);

  typedef enum logic [3:0] {
    PH_DELTA     = 4'd0,
    PH_STATUS    = 4'd1,
    PH_DATA1     = 4'd2,
    PH_DATA2     = 4'd3,
    PH_META_TYPE = 4'd4,
    PH_META_LEN  = 4'd5,
    PH_META_BODY = 4'd6,
    PH_SYSEX_LEN = 4'd7,
    PH_SKIP      = 4'd8
  } phase_t;

  phase_t      phase_r,   phase_nxt,  phase_b;
  logic [31:0] tick_r,    tick_nxt,   tick_b;
  logic [27:0] acc_r,     acc_nxt,    acc_b;
  logic [7:0]  run_st_r,  run_st_nxt, run_st_b;
  logic [7:0]  cur_st_r,  cur_st_nxt, cur_st_b;
  logic [6:0]  held_r,    held_nxt,   held_b;
  logic [7:0]  meta_r,    meta_nxt,   meta_b;
  logic [27:0] remain_r,  remain_nxt, remain_b;
  logic [31:0] payload_r, payload_nxt, payload_b;

  logic [7:0]  b;
  logic [27:0] vlq;
  logic        vlq_done;
  logic [27:0] remain_dec;
  logic [31:0] payload_sh;
  logic [7:0]  emit_st;
  logic [3:0]  emit_hi;
  logic        emit_one;
  logic        emit_go;
  logic [6:0]  emit_first;
  logic [6:0]  emit_second;
  logic        is_chan_emit;
  logic        is_meta_tt;
  logic [27:0] want_len;
  res_t        res;
  logic        res_valid;

  // Consume the held byte whenever the result register can take a result
  assign adv = stage.valid && out_free;

  // Start of track clears the parse state before the byte is parsed
  always_comb begin
    if (stage.track_start) begin
      phase_b   = PH_DELTA;
      tick_b    = '0;
      acc_b     = '0;
      run_st_b  = '0;
      cur_st_b  = '0;
      held_b    = '0;
      meta_b    = '0;
      remain_b  = '0;
      payload_b = '0;
    end else begin
      phase_b   = phase_r;
      tick_b    = tick_r;
      acc_b     = acc_r;
      run_st_b  = run_st_r;
      cur_st_b  = cur_st_r;
      held_b    = held_r;
      meta_b    = meta_r;
      remain_b  = remain_r;
      payload_b = payload_r;
    end
  end

  assign b          = stage.track_byte;
  assign vlq        = {acc_b[20:0], b[6:0]};
  assign vlq_done   = !b[7];
  assign remain_dec = remain_b - 28'd1;
  assign payload_sh = {payload_b[23:0], b};
  assign is_meta_tt = (meta_b == META_TEMPO) || (meta_b == META_TSIG);
  assign want_len   = (meta_b == META_TEMPO) ? LEN_TEMPO : LEN_TSIG;

  // Next state and result for the byte at hand
  always_comb begin
    phase_nxt    = phase_b;
    tick_nxt     = tick_b;
    acc_nxt      = acc_b;
    run_st_nxt   = run_st_b;
    cur_st_nxt   = cur_st_b;
    held_nxt     = held_b;
    meta_nxt     = meta_b;
    remain_nxt   = remain_b;
    payload_nxt  = payload_b;
    is_chan_emit = 1'b0;
    emit_st      = cur_st_b;
    emit_first   = held_b;
    emit_second  = b[6:0];
    res          = '0;
    res_valid    = 1'b0;

    case (phase_b)
      PH_STATUS: begin
        if (b[7]) begin
          if (b[7:4] == 4'hf) begin
            run_st_nxt = '0;
            if (b == STATUS_META) begin
              phase_nxt = PH_META_TYPE;
            end else if (b == STATUS_SYSEX || b == STATUS_ESC) begin
              acc_nxt   = '0;
              phase_nxt = PH_SYSEX_LEN;
            end else begin
              phase_nxt = PH_DELTA;
            end
          end else begin
            run_st_nxt = b;
            cur_st_nxt = b;
            phase_nxt  = PH_DATA1;
          end
        end else if (run_st_b[7]) begin
          // Running status: this byte is the first data byte
          cur_st_nxt = run_st_b;
          held_nxt   = b[6:0];
          emit_st    = run_st_b;
          emit_first = b[6:0];
          if (run_st_b[7:4] == HI_PROGRAM || run_st_b[7:4] == HI_PRESSURE) begin
            is_chan_emit = 1'b1;
          end else begin
            phase_nxt = PH_DATA2;
          end
        end else begin
          // No status held: reparse as delta time
          acc_nxt   = vlq;
          phase_nxt = PH_DELTA;
          if (vlq_done) begin
            tick_nxt  = tick_b + 32'(vlq);
            acc_nxt   = '0;
            phase_nxt = PH_STATUS;
          end
        end
      end
      PH_DATA1: begin
        held_nxt   = b[6:0];
        emit_first = b[6:0];
        if (cur_st_b[7:4] == HI_PROGRAM || cur_st_b[7:4] == HI_PRESSURE) begin
          is_chan_emit = 1'b1;
        end else begin
          phase_nxt = PH_DATA2;
        end
      end
      PH_DATA2: begin
        is_chan_emit = 1'b1;
      end
      PH_META_TYPE: begin
        meta_nxt  = b;
        acc_nxt   = '0;
        phase_nxt = PH_META_LEN;
      end
      PH_META_LEN: begin
        acc_nxt = vlq;
        if (vlq_done) begin
          remain_nxt  = vlq;
          acc_nxt     = '0;
          payload_nxt = '0;
          phase_nxt   = (vlq == '0) ? PH_DELTA : PH_SKIP;
          if (is_meta_tt) begin
            if (vlq != want_len) begin
              res_valid  = 1'b1;
              res.kind   = KIND_BAD_META;
              res.tick   = tick_b;
              res.status = STATUS_META;
            end else begin
              phase_nxt = PH_META_BODY;
            end
          end
        end
      end
      PH_META_BODY: begin
        payload_nxt = payload_sh;
        remain_nxt  = remain_dec;
        if (remain_dec == '0) begin
          phase_nxt  = PH_DELTA;
          res_valid  = 1'b1;
          res.tick   = tick_b;
          res.status = STATUS_META;
          if (meta_b == META_TEMPO) begin
            res.kind        = KIND_TEMPO;
            res.tempo_value = payload_sh[23:0];
          end else begin
            res.kind                       = KIND_TSIG;
            res.numerator                  = payload_sh[31:24];
            res.denominator_power          = payload_sh[23:16];
            res.clocks_per_click           = payload_sh[15:8];
            res.thirty_seconds_per_quarter = payload_sh[7:0];
          end
        end
      end
      PH_SYSEX_LEN: begin
        acc_nxt = vlq;
        if (vlq_done) begin
          remain_nxt = vlq;
          acc_nxt    = '0;
          phase_nxt  = (vlq == '0) ? PH_DELTA : PH_SKIP;
        end
      end
      PH_SKIP: begin
        remain_nxt = remain_dec;
        if (remain_dec == '0) begin
          phase_nxt = PH_DELTA;
        end
      end
      default: begin
        // Delta time, also for codes with no meaning
        acc_nxt   = vlq;
        phase_nxt = PH_DELTA;
        if (vlq_done) begin
          tick_nxt  = tick_b + 32'(vlq);
          acc_nxt   = '0;
          phase_nxt = PH_STATUS;
        end
      end
    endcase

    // Finish a channel event; drop aftertouch and channel pressure
    emit_hi  = emit_st[7:4];
    emit_one = (emit_hi == HI_PROGRAM) || (emit_hi == HI_PRESSURE);
    emit_go  = (emit_hi != HI_AFTERTOUCH) && (emit_hi != HI_PRESSURE);
    if (is_chan_emit) begin
      phase_nxt = PH_DELTA;
      if (emit_go) begin
        res_valid       = 1'b1;
        res.kind        = KIND_CHAN;
        res.tick        = tick_b;
        res.status      = emit_st;
        res.first_data  = emit_first;
        res.second_data = emit_one ? 7'd0 : emit_second;
        res.data_count  = emit_one ? 2'd1 : 2'd2;
      end
    end
  end

  // Hold state; advance on each consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_DELTA;
      tick_r    <= '0;
      acc_r     <= '0;
      run_st_r  <= '0;
      cur_st_r  <= '0;
      held_r    <= '0;
      meta_r    <= '0;
      remain_r  <= '0;
      payload_r <= '0;
    end else if (adv) begin
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      acc_r     <= acc_nxt;
      run_st_r  <= run_st_nxt;
      cur_st_r  <= cur_st_nxt;
      held_r    <= held_nxt;
      meta_r    <= meta_nxt;
      remain_r  <= remain_nxt;
      payload_r <= payload_nxt;
    end
  end

  assign load.valid = adv && res_valid;
  assign load.res   = res;

`ifndef ASSERT_OFF
  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(tick_r) && $stable(phase_r))
    else $error("parser state moved without a consumed byte");

  a_chan_ends_event: assert property (@(posedge clk) disable iff (!rst_n)
    load.valid && load.res.kind == KIND_CHAN |=> phase_r == PH_DELTA)
    else $error("channel event did not return to delta time");

  a_meta_ends_event: assert property (@(posedge clk) disable iff (!rst_n)
    load.valid && (load.res.kind == KIND_TEMPO || load.res.kind == KIND_TSIG)
    |=> phase_r == PH_DELTA && remain_r == '0)
    else $error("meta event did not close its body");

  a_start_clears_running: assert property (@(posedge clk) disable iff (!rst_n)
    adv && stage.track_start |=> run_st_r == '0)
    else $error("track start left running status set");
`endif

endmodule

// ----- rtl/core/mtp_out_reg.sv -----
// ----------------------------------------------------------------------------
// mtp_out_reg
// Result register: holds one event item until the consumer takes it.
// ----------------------------------------------------------------------------
module mtp_out_reg
  import mtp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  res_load_t load,
  output logic      out_free,
  output logic      out_valid,
  input  logic      out_ready,
  output res_t      out_res
);

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  // Free when empty or drained this cycle
  assign out_free  = !valid_r || out_ready;
  assign valid_nxt = load.valid ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load a new result
  always_ff @(posedge clk) begin
    if (load.valid) begin
      res_r <= load.res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ----- rtl/core/midi_track_event_parser_top.sv -----
// ----------------------------------------------------------------------------
// midi_track_event_parser_top
// MIDI track chunk parser: one byte in per item, channel, tempo and time
// signature events out.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                  | handshake
//  ---------+-----+------------------------------------------+-------------
//  in_ch    | in  | track_byte, track_start                  | valid/ready
//  out_ch   | out | kind, tick, status, data and meta fields | valid/ready
//
//  One byte item per cycle while the result register is free; an accepted
//  byte is held in the input register, and its result is loaded into the
//  result register when the byte is consumed from there.
//  The parse state updates once per consumed byte; the tick add is the
//  longest path.
//  Reset is synchronous, active low, and clears the parse state and both
//  valid flags; track_start clears it again at each track.
//  A stalled result holds the parser; the input register still takes one
//  item meanwhile.
// ----------------------------------------------------------------------------
module midi_track_event_parser_top
  import mtp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  mtp_in_if.sink    in_ch,
  mtp_out_if.source out_ch
);

  stage_t    stage;
  res_load_t load;
  res_t      out_res;
  logic      adv;
  logic      out_free;
  logic      out_valid;

  mtp_in_stage u_in_stage (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_track_byte  (in_ch.track_byte),
    .in_track_start (in_ch.track_start),
    .adv            (adv),
    .stage          (stage)
  );

  mtp_parse_core u_parse_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .stage    (stage),
    .out_free (out_free),
    .adv      (adv),
    .load     (load)
  );

  mtp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  // Drive the result channel
  assign out_ch.valid                      = out_valid;
  assign out_ch.kind                       = out_res.kind;
  assign out_ch.tick                       = out_res.tick;
  assign out_ch.status                     = out_res.status;
  assign out_ch.first_data                 = out_res.first_data;
  assign out_ch.second_data                = out_res.second_data;
  assign out_ch.data_count                 = out_res.data_count;
  assign out_ch.tempo_value                = out_res.tempo_value;
  assign out_ch.numerator                  = out_res.numerator;
  assign out_ch.denominator_power          = out_res.denominator_power;
  assign out_ch.clocks_per_click           = out_res.clocks_per_click;
  assign out_ch.thirty_seconds_per_quarter = out_res.thirty_seconds_per_quarter;

endmodule
